[rtl/core/rational_accumulator_gcd_reduce_unit_assert.svh]
// assertion macros for the rational accumulator
`ifndef RATIONAL_ACCUMULATOR_GCD_REDUCE_UNIT_ASSERT_SVH
`define RATIONAL_ACCUMULATOR_GCD_REDUCE_UNIT_ASSERT_SVH

// implication checked on every clock edge outside reset
`define RAGR_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define RAGR_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[rtl/core/ragr_pkg.sv]
// ----------------------------------------------------------------------------
// ragr_pkg
// shared types, op codes and command structs of the rational accumulator
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ragr_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int IO_WIDTH   = 32;
    localparam int EXP_WIDTH  = 5;
    localparam int CNT_WIDTH  = $clog2(DATA_WIDTH + 1);

    typedef logic [DATA_WIDTH-1:0] word_t;

    typedef enum logic [2:0] {
        OP_LOAD = 3'd0,
        OP_ADD  = 3'd1,
        OP_SUB  = 3'd2,
        OP_MUL  = 3'd3,
        OP_DIV  = 3'd4,
        OP_POW  = 3'd5
    } op_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_ZERO_DEN = 2'd1,
        ST_DIV_ZERO = 2'd2
    } status_t;

    typedef struct packed {
        logic [2:0]           op;
        logic signed [31:0]   operand_num;
        logic signed [31:0]   operand_den;
        logic [EXP_WIDTH-1:0] exponent;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] res_num;
        logic signed [31:0] res_den;
        logic [1:0]         status;
    } out_item_t;

    // datapath micro operations
    typedef enum logic [3:0] {
        DP_NOP,
        DP_LATCH,      // capture input item, operand into x/y
        DP_GCD_INIT,   // magnitudes of x/y into gcd registers
        DP_GCD_STEP,   // one restoring bit step of a remainder of the gcd loop
        DP_DIV_INIT,   // start dividing |x| by g
        DP_DIV_STEP,   // one bit of |x|/g or |y|/g
        DP_DIV_SWAP,   // quotient of x done, start y
        DP_FIX_SIGN,   // apply signs, move sign to numerator
        DP_COMBINE1,   // first product set
        DP_COMBINE2,   // second product set and sum or difference
        DP_POW_INIT,
        DP_POW_STEP,
        DP_COMMIT      // write accumulator, form result
    } dp_cmd_t;

    typedef struct packed {
        logic         od_zero;
        logic         on_zero;
        logic [2:0]   op;
        logic         g_zero;     // gcd of both zero
        logic         rem_done;   // last bit step of a remainder
        logic         gcd_done;   // b reached zero
        logic         div_done;
        logic         pow_done;
    } dp_status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_GCD_INIT,
        S_GCD,
        S_DIV_INIT,
        S_DIV_X,
        S_DIV_Y,
        S_FIX,
        S_COMB1,
        S_COMB2,
        S_POW_INIT,
        S_POW,
        S_COMMIT,
        S_OUT
    } state_t;

endpackage

[rtl/core/ragr_datapath.sv]
// ----------------------------------------------------------------------------
// ragr_datapath
// fraction registers, shared bit-serial remainder/divide unit and multipliers
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ragr_datapath (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  ragr_pkg::dp_cmd_t     cmd,
    input  logic                  reduce_acc,  // reduction target is result not operand
    input  ragr_pkg::in_item_t    in_item,
    output ragr_pkg::dp_status_t  status,
    output ragr_pkg::out_item_t   out_item
);

    localparam int W = ragr_pkg::DATA_WIDTH;

    ragr_pkg::word_t acc_num_reg, acc_num_next;
    ragr_pkg::word_t acc_den_reg, acc_den_next;
    ragr_pkg::word_t x_reg, x_next;         // working numerator
    ragr_pkg::word_t y_reg, y_next;         // working denominator
    ragr_pkg::word_t on_reg, on_next;       // reduced operand
    ragr_pkg::word_t od_reg, od_next;
    ragr_pkg::word_t a_reg, a_next;         // gcd pair
    ragr_pkg::word_t b_reg, b_next;
    ragr_pkg::word_t rem_reg, rem_next;     // partial remainder
    ragr_pkg::word_t quo_reg, quo_next;     // shifting dividend/quotient
    ragr_pkg::word_t p1_reg, p1_next;
    ragr_pkg::word_t p2_reg, p2_next;
    logic [ragr_pkg::CNT_WIDTH-1:0] cnt_reg, cnt_next;
    logic [ragr_pkg::EXP_WIDTH-1:0] exp_reg, exp_next;
    logic [2:0] op_reg, op_next;

    ragr_pkg::word_t mag_x, mag_y, divisor, sub_in;
    logic [W:0]      trial;

    function automatic ragr_pkg::word_t mag(input ragr_pkg::word_t v);
        return v[W-1] ? (~v + 1'b1) : v;
    endfunction

    assign mag_x   = mag(x_reg);
    assign mag_y   = mag(y_reg);
    // gcd steps divide a by b, reduction steps divide by the gcd held in a
    assign divisor = (cmd == ragr_pkg::DP_GCD_STEP) ? b_reg : a_reg;
    assign sub_in  = {rem_reg[W-2:0], quo_reg[W-1]};
    assign trial   = {rem_reg[W-1], sub_in} - {1'b0, divisor};

    always_comb begin
        acc_num_next = acc_num_reg;
        acc_den_next = acc_den_reg;
        x_next   = x_reg;
        y_next   = y_reg;
        on_next  = on_reg;
        od_next  = od_reg;
        a_next   = a_reg;
        b_next   = b_reg;
        rem_next = rem_reg;
        quo_next = quo_reg;
        p1_next  = p1_reg;
        p2_next  = p2_reg;
        cnt_next = cnt_reg;
        exp_next = exp_reg;
        op_next  = op_reg;
        case (cmd)
            ragr_pkg::DP_LATCH: begin
                op_next  = in_item.op;
                exp_next = in_item.exponent;
                x_next   = ragr_pkg::word_t'(in_item.operand_num);
                y_next   = ragr_pkg::word_t'(in_item.operand_den);
            end
            ragr_pkg::DP_GCD_INIT: begin
                a_next   = mag_x;
                b_next   = mag_y;
                rem_next = '0;
                quo_next = mag_x;
                cnt_next = '0;
            end
            ragr_pkg::DP_GCD_STEP: begin
                // one restoring step of a mod b
                if (!trial[W]) begin
                    rem_next = trial[W-1:0];
                end else begin
                    rem_next = sub_in;
                end
                quo_next = {quo_reg[W-2:0], 1'b0};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == ragr_pkg::CNT_WIDTH'(W - 1)) begin
                    a_next   = b_reg;
                    b_next   = (!trial[W]) ? trial[W-1:0] : sub_in;
                    rem_next = '0;
                    quo_next = b_reg;
                    cnt_next = '0;
                end
            end
            ragr_pkg::DP_DIV_INIT: begin
                rem_next = '0;
                quo_next = mag_x;
                cnt_next = '0;
            end
            ragr_pkg::DP_DIV_STEP: begin
                if (!trial[W]) begin
                    rem_next = trial[W-1:0];
                end else begin
                    rem_next = sub_in;
                end
                quo_next = {quo_reg[W-2:0], ~trial[W]};
                cnt_next = cnt_reg + 1'b1;
            end
            ragr_pkg::DP_DIV_SWAP: begin
                p1_next  = quo_reg;
                rem_next = '0;
                quo_next = mag_y;
                cnt_next = '0;
            end
            ragr_pkg::DP_FIX_SIGN: begin
                x_next = x_reg[W-1] ? (~p1_reg + 1'b1) : p1_reg;
                y_next = y_reg[W-1] ? (~quo_reg + 1'b1) : quo_reg;
                if (y_reg[W-1]) begin
                    x_next = x_reg[W-1] ? p1_reg : (~p1_reg + 1'b1);
                    y_next = quo_reg;
                end
                // zero gcd: both parts zero, pair kept as it is
                if (a_reg == '0) begin
                    x_next = x_reg;
                    y_next = y_reg;
                end
                if (!reduce_acc) begin
                    on_next = x_next;
                    od_next = y_next;
                end
            end
            ragr_pkg::DP_COMBINE1: begin
                case (op_reg)
                    ragr_pkg::OP_ADD, ragr_pkg::OP_SUB: begin
                        p1_next = acc_num_reg * od_reg;
                        p2_next = on_reg * acc_den_reg;
                    end
                    ragr_pkg::OP_MUL: begin
                        p1_next = acc_num_reg * on_reg;
                        p2_next = '0;
                    end
                    ragr_pkg::OP_DIV: begin
                        p1_next = acc_num_reg * od_reg;
                        p2_next = '0;
                    end
                    default: begin
                        p1_next = on_reg;
                        p2_next = '0;
                    end
                endcase
            end
            ragr_pkg::DP_COMBINE2: begin
                x_next = (op_reg == ragr_pkg::OP_SUB) ? (p1_reg - p2_reg)
                                                      : (p1_reg + p2_reg);
                case (op_reg)
                    ragr_pkg::OP_DIV: y_next = acc_den_reg * on_reg;
                    ragr_pkg::OP_LOAD: y_next = od_reg;
                    default:          y_next = acc_den_reg * od_reg;
                endcase
            end
            ragr_pkg::DP_POW_INIT: begin
                x_next = W'(1);
                y_next = W'(1);
            end
            ragr_pkg::DP_POW_STEP: begin
                x_next   = x_reg * acc_num_reg;
                y_next   = y_reg * acc_den_reg;
                exp_next = exp_reg - 1'b1;
            end
            ragr_pkg::DP_COMMIT: begin
                acc_num_next = x_reg;
                acc_den_next = y_reg;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_num_reg <= '0;
            acc_den_reg <= W'(1);
        end else begin
            acc_num_reg <= acc_num_next;
            acc_den_reg <= acc_den_next;
        end
        x_reg   <= x_next;
        y_reg   <= y_next;
        on_reg  <= on_next;
        od_reg  <= od_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        p1_reg  <= p1_next;
        p2_reg  <= p2_next;
        cnt_reg <= cnt_next;
        exp_reg <= exp_next;
        op_reg  <= op_next;
    end

    assign status.od_zero  = (y_reg == '0);
    assign status.on_zero  = (x_reg == '0);
    assign status.op       = op_reg;
    assign status.g_zero   = (a_reg == '0);
    assign status.rem_done = (cnt_reg == ragr_pkg::CNT_WIDTH'(W - 1));
    assign status.gcd_done = (b_reg == '0);
    assign status.div_done = (cnt_reg == ragr_pkg::CNT_WIDTH'(W));
    assign status.pow_done = (exp_reg == '0);

    assign out_item.res_num = 32'(signed'(acc_num_reg));
    assign out_item.res_den = 32'(signed'(acc_den_reg));
    assign out_item.status  = 2'(ragr_pkg::ST_OK);

endmodule

[rtl/core/ragr_ctrl.sv]
// ----------------------------------------------------------------------------
// ragr_ctrl
// sequencer for check, operand reduction, combine, power and result reduction
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ragr_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  out_free,
    output logic                  out_load,
    output logic [1:0]            out_status,
    input  ragr_pkg::dp_status_t  status,
    output ragr_pkg::dp_cmd_t     cmd,
    output logic                  reduce_acc
);

    ragr_pkg::state_t state_reg, state_next;
    logic             racc_reg, racc_next;
    logic [1:0]       st_reg, st_next;

    always_comb begin
        state_next = state_reg;
        racc_next  = racc_reg;
        st_next    = st_reg;
        case (state_reg)
            ragr_pkg::S_IDLE: begin
                if (s_valid) begin
                    state_next = ragr_pkg::S_CHECK;
                end
            end
            ragr_pkg::S_CHECK: begin
                st_next   = 2'(ragr_pkg::ST_OK);
                racc_next = 1'b0;
                if (status.op > 3'(ragr_pkg::OP_POW)) begin
                    state_next = ragr_pkg::S_OUT;
                end else if (status.op == 3'(ragr_pkg::OP_POW)) begin
                    state_next = ragr_pkg::S_POW_INIT;
                end else if (status.od_zero) begin
                    st_next    = 2'(ragr_pkg::ST_ZERO_DEN);
                    state_next = ragr_pkg::S_OUT;
                end else if (status.op == 3'(ragr_pkg::OP_DIV) && status.on_zero) begin
                    st_next    = 2'(ragr_pkg::ST_DIV_ZERO);
                    state_next = ragr_pkg::S_OUT;
                end else begin
                    state_next = ragr_pkg::S_GCD_INIT;
                end
            end
            ragr_pkg::S_GCD_INIT: state_next = ragr_pkg::S_GCD;
            ragr_pkg::S_GCD: begin
                if (status.gcd_done) begin
                    state_next = status.g_zero ? ragr_pkg::S_FIX : ragr_pkg::S_DIV_INIT;
                end
            end
            ragr_pkg::S_DIV_INIT: state_next = ragr_pkg::S_DIV_X;
            ragr_pkg::S_DIV_X: begin
                if (status.div_done) begin
                    state_next = ragr_pkg::S_DIV_Y;
                end
            end
            ragr_pkg::S_DIV_Y: begin
                if (status.div_done) begin
                    state_next = ragr_pkg::S_FIX;
                end
            end
            ragr_pkg::S_FIX: begin
                state_next = racc_reg ? ragr_pkg::S_COMMIT : ragr_pkg::S_COMB1;
            end
            ragr_pkg::S_COMB1: state_next = ragr_pkg::S_COMB2;
            ragr_pkg::S_COMB2: begin
                racc_next  = 1'b1;
                state_next = ragr_pkg::S_GCD_INIT;
            end
            ragr_pkg::S_POW_INIT: state_next = ragr_pkg::S_POW;
            ragr_pkg::S_POW: begin
                if (status.pow_done) begin
                    racc_next  = 1'b1;
                    state_next = ragr_pkg::S_GCD_INIT;
                end
            end
            ragr_pkg::S_COMMIT: state_next = ragr_pkg::S_OUT;
            ragr_pkg::S_OUT: begin
                if (out_free) begin
                    state_next = ragr_pkg::S_IDLE;
                end
            end
            default: state_next = ragr_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        cmd      = ragr_pkg::DP_NOP;
        s_ready  = 1'b0;
        out_load = 1'b0;
        case (state_reg)
            ragr_pkg::S_IDLE: begin
                s_ready = 1'b1;
                cmd     = ragr_pkg::DP_LATCH;
            end
            ragr_pkg::S_GCD_INIT: cmd = ragr_pkg::DP_GCD_INIT;
            ragr_pkg::S_GCD:      cmd = status.gcd_done ? ragr_pkg::DP_DIV_INIT
                                                        : ragr_pkg::DP_GCD_STEP;
            ragr_pkg::S_DIV_INIT: cmd = ragr_pkg::DP_DIV_INIT;
            ragr_pkg::S_DIV_X:    cmd = status.div_done ? ragr_pkg::DP_DIV_SWAP
                                                        : ragr_pkg::DP_DIV_STEP;
            ragr_pkg::S_DIV_Y:    cmd = status.div_done ? ragr_pkg::DP_NOP
                                                        : ragr_pkg::DP_DIV_STEP;
            ragr_pkg::S_FIX:      cmd = ragr_pkg::DP_FIX_SIGN;
            ragr_pkg::S_COMB1:    cmd = ragr_pkg::DP_COMBINE1;
            ragr_pkg::S_COMB2:    cmd = ragr_pkg::DP_COMBINE2;
            ragr_pkg::S_POW_INIT: cmd = ragr_pkg::DP_POW_INIT;
            ragr_pkg::S_POW:      cmd = status.pow_done ? ragr_pkg::DP_NOP
                                                        : ragr_pkg::DP_POW_STEP;
            ragr_pkg::S_COMMIT:   cmd = ragr_pkg::DP_COMMIT;
            ragr_pkg::S_OUT:      out_load = out_free;
            default:              cmd = ragr_pkg::DP_NOP;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ragr_pkg::S_IDLE;
            racc_reg  <= 1'b0;
            st_reg    <= 2'(ragr_pkg::ST_OK);
        end else begin
            state_reg <= state_next;
            racc_reg  <= racc_next;
            st_reg    <= st_next;
        end
    end

    assign reduce_acc = racc_reg;
    assign out_status = st_reg;

endmodule

[rtl/core/rational_accumulator_gcd_reduce_unit.sv]
// a rejected or no-op item goes straight from the check to the result register
// a gcd pass runs bit-serial euclid remainders (up to about 46), then divides both parts by the gcd
// other ops run two gcd passes, one on the operand and one on the result
// power: one multiply per exponent step, then a single gcd pass
// one transaction in flight; next input taken the cycle after the result register loads
// reset (aresetn, synchronous, active low) sets the accumulator to 0/1 and idles
// ----------------------------------------------------------------------------
// rational_accumulator_gcd_reduce_unit
// running fraction with add/sub/mul/div/power and euclidean gcd reduction
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "rational_accumulator_gcd_reduce_unit_assert.svh"

module rational_accumulator_gcd_reduce_unit (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  ragr_pkg::in_item_t   s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output ragr_pkg::out_item_t  m_data
);

    ragr_pkg::dp_cmd_t    cmd;
    ragr_pkg::dp_status_t dp_status;
    ragr_pkg::out_item_t  dp_out;
    logic                 reduce_acc;
    logic                 out_load;
    logic [1:0]           out_status;
    logic                 m_valid_reg, m_valid_next;
    ragr_pkg::out_item_t  m_data_reg, m_data_next;
    logic                 out_free;

    // output register is free when empty or being drained this cycle
    assign out_free = !m_valid_reg || m_ready;

    ragr_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .out_free   (out_free),
        .out_load   (out_load),
        .out_status (out_status),
        .status     (dp_status),
        .cmd        (cmd),
        .reduce_acc (reduce_acc)
    );

    ragr_datapath u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .reduce_acc (reduce_acc),
        .in_item    (s_data),
        .status     (dp_status),
        .out_item   (dp_out)
    );

    // result register, status merged in from the controller
    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (out_load) begin
            m_valid_next       = 1'b1;
            m_data_next        = dp_out;
            m_data_next.status = out_status;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // a load always raises valid in the next cycle
    `RAGR_ASSERT_NEXT(a_load_valid, aclk, aresetn, out_load, m_valid)
    // no new transaction taken while a result is being loaded
    `RAGR_ASSERT_IMPL(a_no_overlap, aclk, aresetn, out_load, !s_ready)
    // status code always meaningful
    `RAGR_ASSERT_IMPL(a_status_ok, aclk, aresetn, m_valid, m_data.status != 2'd3)

endmodule
